>>> rtl/core/svss_pkg.sv
`timescale 1ns / 1ps

package svss_pkg;

  // register indexes of the configuration port
  localparam logic [1:0] REG_REST_TICKS  = 2'd0;
  localparam logic [1:0] REG_DWELL_TICKS = 2'd1;
  localparam logic [1:0] REG_BLANK_LZ    = 2'd2;
  localparam logic [1:0] REG_POINT_TOP   = 2'd3;

  localparam int unsigned NUM_POS = 4;

  typedef enum logic {
    KIND_TICK   = 1'b0,
    KIND_RESULT = 1'b1
  } kind_t;

  // one queued word: its kind and, for results, the decimal split
  typedef struct packed {
    kind_t                        kind;
    logic [NUM_POS-1:0][3:0]      digits;
  } item_t;

  typedef struct packed {
    logic [7:0] rest_ticks;
    logic [7:0] dwell_ticks;
    logic       blank_lz;
    logic       point_top;
  } cfg_t;

  // segments a..g, bit0 is a; codes above nine are dark
  function automatic logic [6:0] glyph(input logic [3:0] d);
    logic [6:0] g;
    case (d)
      4'd0:    g = 7'h3F;
      4'd1:    g = 7'h06;
      4'd2:    g = 7'h5B;
      4'd3:    g = 7'h4F;
      4'd4:    g = 7'h66;
      4'd5:    g = 7'h6D;
      4'd6:    g = 7'h7D;
      4'd7:    g = 7'h07;
      4'd8:    g = 7'h7F;
      4'd9:    g = 7'h6F;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

endpackage

>>> rtl/core/svss_front.sv
`timescale 1ns / 1ps

module svss_front import svss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       in_tuser,   // action
  input  logic [7:0] in_tdata,   // sample
  output logic       head_valid,
  output item_t      head,
  input  logic       pop
);

  localparam int unsigned DEPTH = 2;

  item_t       mem_r [DEPTH];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  item_t       entry;

  // decimal split of sample*4 by reciprocal multiplies
  logic [9:0]  val;
  logic [17:0] prod1;
  logic [6:0]  q1;
  logic [9:0]  q1x10;
  logic [14:0] prod2;
  logic [3:0]  q2;
  logic [6:0]  q2x10;
  logic        q3;

  always_comb begin
    val   = {in_tdata, 2'b00};
    prod1 = 18'(val) * 18'd205;
    q1    = prod1[17:11];
    q1x10 = {3'b000, q1} * 10'd10;
    prod2 = 15'(q1) * 15'd205;
    q2    = prod2[14:11];
    q2x10 = {3'b000, q2} * 7'd10;
    q3    = (q2 >= 4'd10);
    entry.kind      = kind_t'(in_tuser);
    entry.digits[0] = 4'(val - q1x10);
    entry.digits[1] = 4'(q1 - q2x10);
    entry.digits[2] = q3 ? 4'(q2 - 4'd10) : q2;
    entry.digits[3] = {3'b000, q3};
  end

  assign in_tready  = (count_r != 2'(DEPTH));
  assign push       = in_tvalid & in_tready;
  assign head_valid = (count_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = 2'(count_r + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == 2'($past(count_r) + 2'd1)))
    else $error("queue count did not follow a push");

endmodule

>>> rtl/core/svss_back.sv
`timescale 1ns / 1ps

module svss_back import svss_pkg::*; #(
  parameter int unsigned DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        head_valid,
  input  item_t       head,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata
);

  localparam logic [1:0] POS_LAST = 2'(DIGITS - 1);

  logic                    converting_r, converting_nxt;
  logic                    req_sent_r, req_sent_nxt;
  logic [7:0]              rest_cnt_r, rest_cnt_nxt;
  logic [7:0]              dwell_cnt_r, dwell_cnt_nxt;
  logic [1:0]              pos_r, pos_nxt;
  logic [NUM_POS-1:0][3:0] digits_r, digits_nxt;
  logic [3:0]              drv_en_r, drv_en_nxt;
  logic [6:0]              drv_seg_r, drv_seg_nxt;
  logic                    drv_dp_r, drv_dp_nxt;
  logic                    start_r, start_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic [7:0]              rest_inc, dwell_inc;
  logic                    conv_t;
  logic [NUM_POS-1:0]      upper_zero;
  logic                    blank;

  assign pop = head_valid & (~out_valid_r | out_tready);

  // zero test of positions p and above
  always_comb begin
    for (int p = 0; p < NUM_POS; p++) begin
      upper_zero[p] = 1'b1;
      for (int k = p; k < NUM_POS; k++) begin
        if (digits_r[k] != 4'd0) upper_zero[p] = 1'b0;
      end
    end
    blank = (pos_r != 2'd0) & cfg.blank_lz & upper_zero[pos_r];
  end

  always_comb begin
    converting_nxt = converting_r;
    req_sent_nxt   = req_sent_r;
    rest_cnt_nxt   = rest_cnt_r;
    dwell_cnt_nxt  = dwell_cnt_r;
    pos_nxt        = pos_r;
    digits_nxt     = digits_r;
    drv_en_nxt     = drv_en_r;
    drv_seg_nxt    = drv_seg_r;
    drv_dp_nxt     = drv_dp_r;
    start_nxt      = start_r;
    rest_inc       = (rest_cnt_r == 8'hFF) ? rest_cnt_r : 8'(rest_cnt_r + 8'd1);
    dwell_inc      = (dwell_cnt_r == 8'hFF) ? dwell_cnt_r : 8'(dwell_cnt_r + 8'd1);
    conv_t         = converting_r | (rest_inc > cfg.rest_ticks);
    out_valid_nxt  = pop | (out_valid_r & ~out_tready);

    if (pop) begin
      start_nxt = 1'b0;
      case (head.kind)
        KIND_RESULT: begin
          // results without an outstanding request are dropped
          if (converting_r && req_sent_r) begin
            digits_nxt     = head.digits;
            req_sent_nxt   = 1'b0;
            rest_cnt_nxt   = 8'd0;
            converting_nxt = 1'b0;
          end
        end
        KIND_TICK: begin
          rest_cnt_nxt   = rest_inc;
          dwell_cnt_nxt  = dwell_inc;
          converting_nxt = conv_t;
          start_nxt      = conv_t & ~req_sent_r;
          req_sent_nxt   = req_sent_r | conv_t;
          if (dwell_inc >= cfg.dwell_ticks) begin
            dwell_cnt_nxt = 8'd0;
            if (blank) begin
              drv_en_nxt  = 4'd0;
              drv_seg_nxt = 7'd0;
              drv_dp_nxt  = 1'b0;
            end else begin
              drv_en_nxt  = 4'(1) << pos_r;
              drv_seg_nxt = glyph(digits_r[pos_r]);
              drv_dp_nxt  = (pos_r == 2'd3) & cfg.point_top;
            end
            pos_nxt = (pos_r >= POS_LAST) ? 2'd0 : 2'(pos_r + 2'd1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      converting_r <= 1'b1;
      req_sent_r   <= 1'b0;
      rest_cnt_r   <= 8'd0;
      dwell_cnt_r  <= 8'd0;
      pos_r        <= 2'd0;
      digits_r     <= '0;
      drv_en_r     <= 4'd0;
      drv_seg_r    <= 7'd0;
      drv_dp_r     <= 1'b0;
      start_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      converting_r <= converting_nxt;
      req_sent_r   <= req_sent_nxt;
      rest_cnt_r   <= rest_cnt_nxt;
      dwell_cnt_r  <= dwell_cnt_nxt;
      pos_r        <= pos_nxt;
      digits_r     <= digits_nxt;
      drv_en_r     <= drv_en_nxt;
      drv_seg_r    <= drv_seg_nxt;
      drv_dp_r     <= drv_dp_nxt;
      start_r      <= start_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, drv_dp_r, drv_seg_r, drv_en_r, start_r};

  a_start_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> (req_sent_r && converting_r))
    else $error("conversion request without request state");

  a_result_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.kind == KIND_RESULT) |=> !start_r)
    else $error("request raised on a result word");

  a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(drv_en_r))
    else $error("more than one digit enabled");

endmodule

>>> rtl/core/sampled_value_seven_segment_scanner.sv
`timescale 1ns / 1ps
// an accepted word is written to the queue, then popped into the registered output word
// one word per cycle while out_tready holds; the back end retires one queued word per cycle
// a two-entry queue between front and back lets either side stall alone
// reset: synchronous active-low rst_n; config returns to defaults, a conversion
// is pending, scan at the ones digit, display dark, queue and output empty

module sampled_value_seven_segment_scanner import svss_pkg::*; #(
  parameter int unsigned DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,    // [0] action: 0 tick, 1 converter result
  input  logic [7:0]  in_tdata,    // [7:0] sample
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [0] start_conversion, [4:1] digit_enable,
                                   // [11:5] segments, [12] decimal_point, rest zero
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  cfg_t  cfg_r, cfg_nxt;
  logic  head_valid;
  item_t head;
  logic  pop;

  // configuration registers, write only
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_REST_TICKS:  cfg_nxt.rest_ticks  = cfg_wdata;
        REG_DWELL_TICKS: cfg_nxt.dwell_ticks = cfg_wdata;
        REG_BLANK_LZ:    cfg_nxt.blank_lz    = cfg_wdata[0];
        REG_POINT_TOP:   cfg_nxt.point_top   = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rest_ticks  <= 8'd10;
      cfg_r.dwell_ticks <= 8'd3;
      cfg_r.blank_lz    <= 1'b1;
      cfg_r.point_top   <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: takes words, splits results into decimal digits, queues them
  svss_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // back: conversion pacing, digit scan, registered output word
  svss_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
